FILE: hw/rtl/bezier_shaped_error_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// bezier shaped error controller - assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BEZIER_SHAPED_ERROR_CONTROLLER_UNIT_DEFINES_SVH
`define BEZIER_SHAPED_ERROR_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define BSEC_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSEC_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bsec_pkg.sv
// ----------------------------------------------------------------------------
// bsec_pkg
// Types, constants and helpers of the bezier shaped error controller.
// ----------------------------------------------------------------------------
package bsec_pkg;

	localparam int DATA_WIDTH      = 32;
	localparam int NUM_POINT_REGS  = 6;
	localparam int MAX_POINTS_DEF  = 6;
	localparam int T_ITER_DEF      = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int PADDR_W         = 6;
	localparam int PDATA_W         = 64;
	localparam int REG_IDX_W       = 3;

	localparam logic [REG_IDX_W-1:0] REG_CURVE_ORDER = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POINT0      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_POINT5      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd7;

	localparam logic [2:0]  CURVE_ORDER_RST = 3'd3;
	localparam logic [30:0] OUT_LIMIT_RST   = 31'h7fff_ffff;

	typedef struct packed {
		logic [2:0]                         curve_order;
		logic [NUM_POINT_REGS-1:0][63:0]    point;
		logic [30:0]                        out_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_LOAD,
		S_MUL,
		S_ADD,
		S_CMP,
		S_OUT
	} state_t;

	// which = 0 selects x (low half), 1 selects y (high half)
	function automatic logic signed [DATA_WIDTH-1:0] coord(cfg_t c, logic [2:0] idx,
			logic which);
		logic [63:0] p;
		p = c.point[idx];
		return which ? $signed(p[63:32]) : $signed(p[31:0]);
	endfunction

endpackage

FILE: hw/rtl/bsec_regs.sv
// ----------------------------------------------------------------------------
// bsec_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module bsec_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bsec_pkg::PADDR_W-1:0]   paddr,
	input  logic [bsec_pkg::PDATA_W-1:0]   pwdata,
	output logic [bsec_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output bsec_pkg::cfg_t                 cfg
);
	import bsec_pkg::*;

	cfg_t                  cfg_q;
	logic [REG_IDX_W-1:0]  idx;
	logic                  wr_en;

	assign idx    = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.curve_order <= CURVE_ORDER_RST;
			cfg_q.point       <= '0;
			cfg_q.out_limit   <= OUT_LIMIT_RST;
		end else if (wr_en) begin
			case (idx) inside
				REG_CURVE_ORDER: cfg_q.curve_order <= pwdata[2:0];
				[REG_POINT0:REG_POINT5]: cfg_q.point[idx - REG_POINT0] <= pwdata;
				REG_OUT_LIMIT: cfg_q.out_limit <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx) inside
			REG_CURVE_ORDER: prdata = {61'd0, cfg_q.curve_order};
			[REG_POINT0:REG_POINT5]: prdata = cfg_q.point[idx - REG_POINT0];
			REG_OUT_LIMIT: prdata = {33'd0, cfg_q.out_limit};
			default: prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/bsec_blend.sv
// ----------------------------------------------------------------------------
// bsec_blend
// Shared de Casteljau blend unit: a + trunc((b - a) * t), product registered on en.
// ----------------------------------------------------------------------------
module bsec_blend #(
	parameter int FRAC_BITS = bsec_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [bsec_pkg::DATA_WIDTH-1:0] a,
	input  logic signed [bsec_pkg::DATA_WIDTH-1:0] b,
	input  logic [FRAC_BITS:0]                     t,
	output logic signed [bsec_pkg::DATA_WIDTH-1:0] res
);
	import bsec_pkg::*;

	logic signed [DATA_WIDTH:0]            d;
	logic [DATA_WIDTH:0]                   d_abs;
	logic [DATA_WIDTH+FRAC_BITS:0]         full;
	logic [DATA_WIDTH:0]                   prod_s1;
	logic                                  neg_s1;
	logic signed [DATA_WIDTH-1:0]          a_s1;
	logic signed [DATA_WIDTH+1:0]          sum;

	always_comb begin
		d     = $signed({b[DATA_WIDTH-1], b}) - $signed({a[DATA_WIDTH-1], a});
		d_abs = d[DATA_WIDTH] ? (DATA_WIDTH+1)'(-d) : (DATA_WIDTH+1)'(d);
		full  = d_abs[DATA_WIDTH-1:0] * t;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= full[DATA_WIDTH+FRAC_BITS:FRAC_BITS];
			neg_s1  <= d[DATA_WIDTH];
			a_s1    <= a;
		end
	end

	always_comb begin
		if (neg_s1)
			sum = (DATA_WIDTH+2)'(a_s1) - $signed({1'b0, prod_s1});
		else
			sum = (DATA_WIDTH+2)'(a_s1) + $signed({1'b0, prod_s1});
		res = sum[DATA_WIDTH-1:0];
	end

endmodule

FILE: hw/rtl/bezier_shaped_error_controller_unit.sv
// ----------------------------------------------------------------------------
// bezier_shaped_error_controller_unit
// Error to drive through a Bezier gain curve, bisection on t, shared blend unit.
// ----------------------------------------------------------------------------
// channel   dir   handshake          payload
// s_*       in    tvalid/tready      reference, feedback
// m_*       out   tvalid/tready      drive, error_value
// apb       in    psel/penable       register write/read, pready tied high
//
// one curve evaluation runs S_LOAD, then S_MUL and S_ADD for each blend, and a
// final S_MUL pass; each of the T_ITERATIONS bisection steps adds an S_CMP state;
// a transaction passes S_PREP, the bisection, a y evaluation at hi and S_OUT
// s_tready is high only in idle; a finished result waits in the output
// register, a new transaction is taken while it waits
// reset is asynchronous and clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module bezier_shaped_error_controller_unit #(
	parameter int MAX_POINTS   = bsec_pkg::MAX_POINTS_DEF,
	parameter int T_ITERATIONS = bsec_pkg::T_ITER_DEF,
	parameter int FRAC_BITS    = bsec_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [63:0]                    s_tdata,   // reference, feedback
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [63:0]                    m_tdata,   // drive, error_value
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bsec_pkg::PADDR_W-1:0]   paddr,
	input  logic [bsec_pkg::PDATA_W-1:0]   pwdata,
	output logic [bsec_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import bsec_pkg::*;

	localparam int LEN_W = $clog2(MAX_POINTS + 1);
	localparam int IT_W  = $clog2(T_ITERATIONS);
	localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	cfg_t   cfg;
	state_t state_q, state_d;

	logic signed [DATA_WIDTH-1:0] ref_q, fbk_q, err_q;
	logic signed [DATA_WIDTH:0]   mag_q;
	logic                         neg_q;
	logic [FRAC_BITS:0]           lo_q, hi_q, t_q;
	logic [IT_W-1:0]              iter_q;
	logic                         eval_y_q;
	logic [LEN_W-1:0]             len_q, pos_q;
	logic signed [DATA_WIDTH-1:0] w_q [MAX_POINTS];
	logic                         m_valid_q;
	logic [63:0]                  m_data_q;

	logic [2:0]                   deg;
	logic                         s_acc, blend_en, out_load, last_step, below;
	logic signed [DATA_WIDTH-1:0] blend_res, xlast, err_w;
	logic signed [DATA_WIDTH:0]   err_x, mag_w, xl_x;
	logic signed [DATA_WIDTH+1:0] drv_x, lim_x;
	logic [FRAC_BITS+1:0]         mid_sum;
	logic [LEN_W-1:0]             wr_idx;

	bsec_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsec_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk (clk),
		.en  (blend_en),
		.a   (w_q[0]),
		.b   (w_q[1]),
		.t   (t_q),
		.res (blend_res)
	);

	assign deg = (cfg.curve_order > 3'(MAX_POINTS - 1)) ? 3'(MAX_POINTS - 1)
		: cfg.curve_order;
	assign xlast     = coord(cfg, deg, 1'b0);
	assign s_acc     = s_tvalid & s_tready;
	assign last_step = (pos_q == len_q - LEN_W'(2));
	assign wr_idx    = last_step ? len_q - LEN_W'(2) : len_q - LEN_W'(1);
	assign below     = $signed({w_q[0][DATA_WIDTH-1], w_q[0]}) < mag_q;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	// saturated error and clamped magnitude
	always_comb begin
		err_x = $signed({ref_q[DATA_WIDTH-1], ref_q}) - $signed({fbk_q[DATA_WIDTH-1], fbk_q});
		if (err_x[DATA_WIDTH] != err_x[DATA_WIDTH-1])
			err_w = err_x[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
				: {1'b0, {(DATA_WIDTH-1){1'b1}}};
		else
			err_w = err_x[DATA_WIDTH-1:0];
		mag_w = err_w[DATA_WIDTH-1] ? -(DATA_WIDTH+1)'(err_w) : (DATA_WIDTH+1)'(err_w);
		xl_x  = (DATA_WIDTH+1)'(xlast);
		if (mag_w > xl_x)
			mag_w = xl_x[DATA_WIDTH] ? -xl_x : xl_x;
	end

	// sign and limit
	always_comb begin
		drv_x = neg_q ? -(DATA_WIDTH+2)'(w_q[0]) : (DATA_WIDTH+2)'(w_q[0]);
		lim_x = (DATA_WIDTH+2)'({1'b0, cfg.out_limit});
		if (drv_x > lim_x)
			drv_x = lim_x;
		else if (drv_x < -lim_x)
			drv_x = -lim_x;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_acc) state_d = S_PREP;
			S_PREP: state_d = S_LOAD;
			S_LOAD: state_d = S_MUL;
			S_MUL: begin
				if (len_q == LEN_W'(1))
					state_d = eval_y_q ? S_OUT : S_CMP;
				else
					state_d = S_ADD;
			end
			S_ADD: state_d = S_MUL;
			S_CMP: state_d = S_LOAD;
			S_OUT: if (!m_valid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		blend_en = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_MUL:  blend_en = (len_q != LEN_W'(1));
			S_OUT:  out_load = !m_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_data_q <= {err_q, drv_x[DATA_WIDTH-1:0]};
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					ref_q <= s_tdata[31:0];
					fbk_q <= s_tdata[63:32];
				end
			end
			S_PREP: begin
				err_q    <= err_w;
				neg_q    <= err_w[DATA_WIDTH-1];
				mag_q    <= mag_w;
				lo_q     <= '0;
				hi_q     <= T_ONE;
				iter_q   <= '0;
				eval_y_q <= 1'b0;
			end
			S_LOAD: begin
				t_q   <= eval_y_q ? hi_q : mid_sum[FRAC_BITS+1:1];
				len_q <= LEN_W'(deg) + LEN_W'(1);
				pos_q <= '0;
				for (int j = 0; j < MAX_POINTS; j++)
					w_q[j] <= coord(cfg, 3'(j), eval_y_q);
			end
			S_ADD: begin
				for (int j = 0; j < MAX_POINTS; j++) begin
					if (LEN_W'(j) == wr_idx)
						w_q[j] <= blend_res;
					else if (last_step && j + 2 < MAX_POINTS)
						w_q[j] <= w_q[(j + 2 < MAX_POINTS) ? j + 2 : j];
					else if (!last_step && j + 1 < MAX_POINTS)
						w_q[j] <= w_q[(j + 1 < MAX_POINTS) ? j + 1 : j];
				end
				if (last_step) begin
					len_q <= len_q - LEN_W'(1);
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + LEN_W'(1);
				end
			end
			S_CMP: begin
				if (below)
					lo_q <= t_q;
				else
					hi_q <= t_q;
				iter_q <= iter_q + IT_W'(1);
				if (iter_q == IT_W'(T_ITERATIONS - 1))
					eval_y_q <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/bsec_checker.sv
// ----------------------------------------------------------------------------
// bsec_checker
// Port-level assertions for the bezier shaped error controller.
// ----------------------------------------------------------------------------
`include "bezier_shaped_error_controller_unit_defines.svh"

module bsec_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [63:0]                   m_tdata,
	input logic                          pready
);

	`BSEC_AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output transaction changed")
	`BSEC_AST_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after an accepted transaction")
	`BSEC_AST_NOW(a_result_from_work, $rose(m_tvalid), !$past(s_tready), "result appeared while idle")
	`BSEC_AST_NOW(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind bezier_shaped_error_controller_unit bsec_checker u_bsec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
